// ===== rtl/core/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the packet deframer
// parse phases, event and drop codes, frame constants and the result beat
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam logic [7:0] SYNC_START  = 8'hF3;
    localparam logic [7:0] SYNC_END    = 8'hF4;
    localparam logic [7:0] SERVICE_RST = 8'h5E;
    localparam logic [7:0] CMD_LOW     = 8'h01;
    localparam logic [7:0] CMD_HIGH    = 8'hF0;

    // one-hot parse phases
    typedef enum logic [8:0] {
        PH_WAIT  = 9'b0_0000_0001,
        PH_DEV   = 9'b0_0000_0010,
        PH_SRV   = 9'b0_0000_0100,
        PH_CMD   = 9'b0_0000_1000,
        PH_LENLO = 9'b0_0001_0000,
        PH_LENHI = 9'b0_0010_0000,
        PH_DATA  = 9'b0_0100_0000,
        PH_CHECK = 9'b0_1000_0000,
        PH_END   = 9'b1_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_DONE    = 2'd2,
        EV_DROP    = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        DR_NONE     = 3'd0,
        DR_SERVICE  = 3'd1,
        DR_COMMAND  = 3'd2,
        DR_CHECKSUM = 3'd3,
        DR_END      = 3'd4
    } drop_t;

    typedef struct packed {
        logic        accepted;
        event_t      event_res;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_device;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        drop_t       drop_reason;
    } result_t;

endpackage

// ===== rtl/core/framed_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// framed_packet_deframer_top: byte-serial packet deframer
// frame layout: start 0xF3, device, service, command, length (low byte
// first), payload, additive checksum from device through payload, end 0xF4
// usage:
// - input channel in_valid/in_ready carries one received byte per beat
// - output channel out_valid/out_ready returns exactly one result beat per
//   input beat: accepted flag, event, payload byte and index, held device
//   and command ids, frame length on completion and the drop reason
// - cfg_wr_en/cfg_wr_data write the expected service id (no read-back);
//   write it only while no beats are in flight
// - a byte taken at a clock edge is registered as its result at that same
//   edge when the result register is free; one byte per cycle is sustained
//   while the receiver takes results, set by the single parse step between the frame state and the result register
// - when the receiver stalls, one more byte is taken into a skid stage,
//   then in_ready drops until the receiver takes a result
// - reset clears the parse state to waiting for a start byte, empties both
//   result stages and sets the service id to 0x5E
// ----------------------------------------------------------------------------
module framed_packet_deframer_top
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    // received bytes
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,

    // result beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  event_res,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [7:0]  frame_device,
    output logic [7:0]  frame_command,
    output logic [15:0] frame_length,
    output logic [2:0]  drop_reason
);

    logic [7:0]       service_id_reg;
    logic             in_fire;
    logic             can_load;
    fpd_pkg::result_t step_result;
    fpd_pkg::result_t out_data;

    // service id register, written whenever the enable is up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            service_id_reg <= fpd_pkg::SERVICE_RST;
        end
        else if (cfg_wr_en)
        begin
            service_id_reg <= cfg_wr_data;
        end
    end

    // a byte is taken only when a result stage is free for it
    assign in_ready = can_load;
    assign in_fire  = in_valid && can_load;

    // parse step: frame state in, result beat out
    fpd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_fire),
        .rx_byte    (rx_byte),
        .service_id (service_id_reg),
        .result     (step_result)
    );

    // result register plus skid stage toward the receiver
    fpd_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .load_data (step_result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // unpack the result beat onto its ports
    assign accepted      = out_data.accepted;
    assign event_res     = out_data.event_res;
    assign payload_byte  = out_data.payload_byte;
    assign payload_index = out_data.payload_index;
    assign frame_device  = out_data.frame_device;
    assign frame_command = out_data.frame_command;
    assign frame_length  = out_data.frame_length;
    assign drop_reason   = out_data.drop_reason;

    // a stalled input side means a result is waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result register");

    // a drop reason goes with a drop event and only with it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_res == fpd_pkg::EV_DROP)
                       == (drop_reason != fpd_pkg::DR_NONE)))
        else $error("drop reason and event disagree");

    // dropped bytes are never marked as taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == fpd_pkg::EV_DROP) |-> !accepted)
        else $error("dropped byte marked accepted");

    // payload and completion beats always belong to a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == fpd_pkg::EV_PAYLOAD
                       || event_res == fpd_pkg::EV_DONE)) |-> accepted)
        else $error("frame event on a byte not accepted");

endmodule

// ===== rtl/core/fpd_parser.sv =====
// ----------------------------------------------------------------------------
// fpd_parser: frame parse state machine
// holds the frame state, advanced only on step, and works out the result of one byte per cycle
// ----------------------------------------------------------------------------
module fpd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        service_id,
    output fpd_pkg::result_t  result
);

    fpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      device_reg, device_next;
    logic [7:0]      command_reg, command_next;
    logic [15:0]     length_reg, length_next;
    logic [15:0]     count_reg, count_next;
    logic [7:0]      sum_reg, sum_next;

    logic [7:0]      sum_plus;
    logic [15:0]     count_inc;
    logic [15:0]     length_full;

    assign sum_plus    = sum_reg + rx_byte;
    assign count_inc   = count_reg + 16'd1;
    assign length_full = {rx_byte, length_reg[7:0]};

    always_comb
    begin
        phase_next   = phase_reg;
        device_next  = device_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;

        result               = '0;
        result.event_res     = fpd_pkg::EV_NONE;
        result.drop_reason   = fpd_pkg::DR_NONE;

        unique case (phase_reg)
            fpd_pkg::PH_WAIT:
            begin
                if (rx_byte == fpd_pkg::SYNC_START)
                begin
                    phase_next      = fpd_pkg::PH_DEV;
                    result.accepted = 1'b1;
                end
            end
            fpd_pkg::PH_DEV:
            begin
                sum_next        = rx_byte;
                device_next     = rx_byte;
                phase_next      = fpd_pkg::PH_SRV;
                result.accepted = 1'b1;
            end
            fpd_pkg::PH_SRV:
            begin
                if (rx_byte == service_id)
                begin
                    sum_next        = sum_plus;
                    phase_next      = fpd_pkg::PH_CMD;
                    result.accepted = 1'b1;
                end
                else
                begin
                    phase_next         = fpd_pkg::PH_WAIT;
                    result.event_res   = fpd_pkg::EV_DROP;
                    result.drop_reason = fpd_pkg::DR_SERVICE;
                end
            end
            fpd_pkg::PH_CMD:
            begin
                sum_next = sum_plus;
                if (rx_byte >= fpd_pkg::CMD_LOW && rx_byte <= fpd_pkg::CMD_HIGH)
                begin
                    command_next    = rx_byte;
                    phase_next      = fpd_pkg::PH_LENLO;
                    result.accepted = 1'b1;
                end
                else
                begin
                    phase_next         = fpd_pkg::PH_WAIT;
                    result.event_res   = fpd_pkg::EV_DROP;
                    result.drop_reason = fpd_pkg::DR_COMMAND;
                end
            end
            fpd_pkg::PH_LENLO:
            begin
                sum_next        = sum_plus;
                length_next     = {8'd0, rx_byte};
                phase_next      = fpd_pkg::PH_LENHI;
                result.accepted = 1'b1;
            end
            fpd_pkg::PH_LENHI:
            begin
                sum_next        = sum_plus;
                length_next     = length_full;
                count_next      = '0;
                // empty payload skips straight to the checksum
                phase_next      = (length_full == 16'd0) ? fpd_pkg::PH_CHECK
                                                         : fpd_pkg::PH_DATA;
                result.accepted = 1'b1;
            end
            fpd_pkg::PH_DATA:
            begin
                sum_next             = sum_plus;
                count_next           = count_inc;
                result.event_res     = fpd_pkg::EV_PAYLOAD;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                result.accepted      = 1'b1;
                if (count_inc == length_reg)
                begin
                    phase_next = fpd_pkg::PH_CHECK;
                end
            end
            fpd_pkg::PH_CHECK:
            begin
                if (rx_byte == sum_reg)
                begin
                    phase_next      = fpd_pkg::PH_END;
                    result.accepted = 1'b1;
                end
                else
                begin
                    phase_next         = fpd_pkg::PH_WAIT;
                    result.event_res   = fpd_pkg::EV_DROP;
                    result.drop_reason = fpd_pkg::DR_CHECKSUM;
                end
            end
            fpd_pkg::PH_END:
            begin
                phase_next = fpd_pkg::PH_WAIT;
                if (rx_byte == fpd_pkg::SYNC_END)
                begin
                    result.accepted     = 1'b1;
                    result.event_res    = fpd_pkg::EV_DONE;
                    result.frame_length = length_reg;
                end
                else
                begin
                    result.event_res   = fpd_pkg::EV_DROP;
                    result.drop_reason = fpd_pkg::DR_END;
                end
            end
            default:
            begin
                phase_next = fpd_pkg::PH_WAIT;
            end
        endcase

        // held ids as they stand after this byte
        result.frame_device  = device_next;
        result.frame_command = command_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= fpd_pkg::PH_WAIT;
            device_reg  <= '0;
            command_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            device_reg  <= device_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

// ===== rtl/core/fpd_skid.sv =====
// ----------------------------------------------------------------------------
// fpd_skid: result register with skid stage
// keeps the input side running for one beat while the receiver stalls
// ----------------------------------------------------------------------------
module fpd_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fpd_pkg::result_t  load_data,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output fpd_pkg::result_t  out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    fpd_pkg::result_t out_data_reg, out_data_next;
    fpd_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_free;

    assign can_load  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (out_free && skid_valid_reg)
        begin
            // skid full means no load this cycle
            out_data_next   = skid_data_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else if (out_free)
        begin
            out_data_next  = load_data;
            out_valid_next = load;
        end
        else if (load)
        begin
            skid_data_next  = load_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
